// ===== hdl/htmlct_pkg.sv =====
// Package for the HTML comment tokenizer: payload types, result codes and byte constants.
`default_nettype none
package htmlct_pkg;

  localparam int unsigned MaxRes = 7;

  localparam logic [1:0] KindText = 2'd0;
  localparam logic [1:0] KindErr  = 2'd1;
  localparam logic [1:0] KindDone = 2'd2;

  localparam logic [2:0] ErrAbrupt   = 3'd0;
  localparam logic [2:0] ErrEof      = 3'd1;
  localparam logic [2:0] ErrNull     = 3'd2;
  localparam logic [2:0] ErrNested   = 3'd3;
  localparam logic [2:0] ErrBadClose = 3'd4;

  localparam logic [7:0] ChDash = 8'h2D;
  localparam logic [7:0] ChGt   = 8'h3E;
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChBang = 8'h21;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChNul  = 8'h00;
  localparam logic [7:0] ChRep0 = 8'hEF;
  localparam logic [7:0] ChRep1 = 8'hBF;
  localparam logic [7:0] ChRep2 = 8'hBD;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] text_byte;
    logic [2:0] error_code;
    logic       last;
  } out_t;

  function automatic out_t mk_res(logic [1:0] kind, logic [7:0] b, logic [2:0] code);
    out_t r;
    r.kind       = kind;
    r.text_byte  = b;
    r.error_code = code;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/html_comment_tokenizer.sv =====
// HTML comment tokenizer: comment states, line-ending folding and result burst buffer.
//
//  channel | direction | signals                              | payload
//  in      | input     | in_valid_i, in_stall_o, in_data_i    | htmlct_pkg::in_t
//  out     | output    | out_valid_o, out_stall_i, out_data_o | htmlct_pkg::out_t
//
// A byte is decoded in the cycle of its transfer and its results (0 to 7) land in a
// result buffer. A stall on the output holds the current result in place; otherwise
// results leave one per cycle, and an item that gives at most one result sustains
// one transfer per cycle. An item with more results holds the input while the buffer
// drains. Reset puts the block in the comment start state with an empty buffer.
`default_nettype none
module html_comment_tokenizer (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire htmlct_pkg::in_t  in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output htmlct_pkg::out_t      out_data_o
);
  import htmlct_pkg::*;

  typedef enum logic [3:0] {
    PH_START        = 4'd0,
    PH_START_DASH   = 4'd1,
    PH_COMMENT      = 4'd2,
    PH_LT           = 4'd3,
    PH_LT_BANG      = 4'd4,
    PH_LT_BANG_DASH = 4'd5,
    PH_LT_BANG_DD   = 4'd6,
    PH_END_DASH     = 4'd7,
    PH_END          = 4'd8,
    PH_END_BANG     = 4'd9
  } phase_e;

  phase_e     phase_q, phase_d;
  logic       crlf_q, crlf_d;
  logic [2:0] rem_q, rem_d;
  out_t       res_q [MaxRes];
  out_t       res_c [MaxRes];
  logic [2:0] cnt_c;
  logic       in_fire, out_fire;

  assign out_valid_o = (rem_q != 3'd0);
  assign out_data_o  = res_q[0];
  assign out_fire    = out_valid_o && !out_stall_i;
  assign in_stall_o  = (rem_q > 3'd1) || ((rem_q == 3'd1) && out_stall_i);
  assign in_fire     = in_valid_i && !in_stall_o;

  always_comb begin
    logic [7:0] c;
    logic       eof;
    logic       drop;
    logic       again;
    phase_e     ph;
    c       = in_data_i.in_byte;
    eof     = in_data_i.end_of_input;
    drop    = 1'b0;
    again   = 1'b1;
    ph      = phase_q;
    cnt_c   = 3'd0;
    for (int i = 0; i < MaxRes; i++) begin
      res_c[i] = '0;
    end
    if (eof) begin
      crlf_d = 1'b0;
    end else if (c == ChCr) begin
      crlf_d = 1'b1;
      c      = ChLf;
    end else if (c == ChLf && crlf_q) begin
      crlf_d = 1'b0;
      drop   = 1'b1;
    end else begin
      crlf_d = 1'b0;
    end

    if (!drop) begin
      for (int s = 0; s < 3; s++) begin
        if (again) begin
          again = 1'b0;
          case (ph)
            PH_START_DASH: begin
              if (eof) begin
                res_c[cnt_c] = mk_res(KindErr, 8'd0, ErrEof);   cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindDone, 8'd0, 3'd0);    cnt_c = cnt_c + 3'd1;
                ph = PH_START;
              end else if (c == ChDash) begin
                ph = PH_END;
              end else if (c == ChGt) begin
                res_c[cnt_c] = mk_res(KindErr, 8'd0, ErrAbrupt); cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindDone, 8'd0, 3'd0);     cnt_c = cnt_c + 3'd1;
                ph = PH_START;
              end else begin
                res_c[cnt_c] = mk_res(KindText, ChDash, 3'd0);  cnt_c = cnt_c + 3'd1;
                ph = PH_COMMENT;
                again = 1'b1;
              end
            end
            PH_COMMENT: begin
              if (eof) begin
                res_c[cnt_c] = mk_res(KindErr, 8'd0, ErrEof);   cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindDone, 8'd0, 3'd0);    cnt_c = cnt_c + 3'd1;
                ph = PH_START;
              end else if (c == ChLt) begin
                res_c[cnt_c] = mk_res(KindText, ChLt, 3'd0);    cnt_c = cnt_c + 3'd1;
                ph = PH_LT;
              end else if (c == ChDash) begin
                ph = PH_END_DASH;
              end else if (c == ChNul) begin
                res_c[cnt_c] = mk_res(KindErr, 8'd0, ErrNull);  cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindText, ChRep0, 3'd0);  cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindText, ChRep1, 3'd0);  cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindText, ChRep2, 3'd0);  cnt_c = cnt_c + 3'd1;
              end else begin
                res_c[cnt_c] = mk_res(KindText, c, 3'd0);       cnt_c = cnt_c + 3'd1;
              end
            end
            PH_LT: begin
              if (!eof && c == ChBang) begin
                res_c[cnt_c] = mk_res(KindText, ChBang, 3'd0);  cnt_c = cnt_c + 3'd1;
                ph = PH_LT_BANG;
              end else if (!eof && c == ChLt) begin
                res_c[cnt_c] = mk_res(KindText, ChLt, 3'd0);    cnt_c = cnt_c + 3'd1;
              end else begin
                ph = PH_COMMENT;
                again = 1'b1;
              end
            end
            PH_LT_BANG: begin
              if (!eof && c == ChDash) begin
                ph = PH_LT_BANG_DASH;
              end else begin
                ph = PH_COMMENT;
                again = 1'b1;
              end
            end
            PH_LT_BANG_DASH: begin
              if (!eof && c == ChDash) begin
                ph = PH_LT_BANG_DD;
              end else begin
                ph = PH_END_DASH;
                again = 1'b1;
              end
            end
            PH_LT_BANG_DD: begin
              if (!eof && c != ChGt) begin
                res_c[cnt_c] = mk_res(KindErr, 8'd0, ErrNested); cnt_c = cnt_c + 3'd1;
              end
              ph = PH_END;
              again = 1'b1;
            end
            PH_END_DASH: begin
              if (eof) begin
                res_c[cnt_c] = mk_res(KindErr, 8'd0, ErrEof);   cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindDone, 8'd0, 3'd0);    cnt_c = cnt_c + 3'd1;
                ph = PH_START;
              end else if (c == ChDash) begin
                ph = PH_END;
              end else begin
                res_c[cnt_c] = mk_res(KindText, ChDash, 3'd0);  cnt_c = cnt_c + 3'd1;
                ph = PH_COMMENT;
                again = 1'b1;
              end
            end
            PH_END: begin
              if (eof) begin
                res_c[cnt_c] = mk_res(KindErr, 8'd0, ErrEof);   cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindDone, 8'd0, 3'd0);    cnt_c = cnt_c + 3'd1;
                ph = PH_START;
              end else if (c == ChGt) begin
                res_c[cnt_c] = mk_res(KindDone, 8'd0, 3'd0);    cnt_c = cnt_c + 3'd1;
                ph = PH_START;
              end else if (c == ChBang) begin
                ph = PH_END_BANG;
              end else if (c == ChDash) begin
                res_c[cnt_c] = mk_res(KindText, ChDash, 3'd0);  cnt_c = cnt_c + 3'd1;
              end else begin
                res_c[cnt_c] = mk_res(KindText, ChDash, 3'd0);  cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindText, ChDash, 3'd0);  cnt_c = cnt_c + 3'd1;
                ph = PH_COMMENT;
                again = 1'b1;
              end
            end
            PH_END_BANG: begin
              if (eof) begin
                res_c[cnt_c] = mk_res(KindErr, 8'd0, ErrEof);   cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindDone, 8'd0, 3'd0);    cnt_c = cnt_c + 3'd1;
                ph = PH_START;
              end else if (c == ChGt) begin
                res_c[cnt_c] = mk_res(KindErr, 8'd0, ErrBadClose); cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindDone, 8'd0, 3'd0);       cnt_c = cnt_c + 3'd1;
                ph = PH_START;
              end else begin
                res_c[cnt_c] = mk_res(KindText, ChDash, 3'd0);  cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindText, ChDash, 3'd0);  cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindText, ChBang, 3'd0);  cnt_c = cnt_c + 3'd1;
                if (c == ChDash) begin
                  ph = PH_END_DASH;
                end else begin
                  ph = PH_COMMENT;
                  again = 1'b1;
                end
              end
            end
            default: begin
              // start state; unused codes behave the same
              if (eof) begin
                ph = PH_COMMENT;
                again = 1'b1;
              end else if (c == ChDash) begin
                ph = PH_START_DASH;
              end else if (c == ChGt) begin
                res_c[cnt_c] = mk_res(KindErr, 8'd0, ErrAbrupt); cnt_c = cnt_c + 3'd1;
                res_c[cnt_c] = mk_res(KindDone, 8'd0, 3'd0);     cnt_c = cnt_c + 3'd1;
                ph = PH_START;
              end else begin
                ph = PH_COMMENT;
                again = 1'b1;
              end
            end
          endcase
        end
      end
    end

    for (int i = 0; i < MaxRes; i++) begin
      res_c[i].last = (cnt_c != 3'd0) && (3'(i) == cnt_c - 3'd1);
    end
    phase_d = ph;
  end

  always_comb begin
    rem_d = rem_q;
    if (in_fire) begin
      rem_d = cnt_c;
    end else if (out_fire) begin
      rem_d = rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      crlf_q  <= 1'b0;
      rem_q   <= 3'd0;
      for (int i = 0; i < MaxRes; i++) begin
        res_q[i] <= '0;
      end
    end else begin
      rem_q <= rem_d;
      if (in_fire) begin
        phase_q <= phase_d;
        crlf_q  <= crlf_d;
        res_q   <= res_c;
      end else if (out_fire) begin
        for (int i = 0; i < MaxRes - 1; i++) begin
          res_q[i] <= res_q[i+1];
        end
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input transfer while a result is stalled");

  a_last_marks_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (rem_q == 3'd1)))
    else $error("last flag out of step with buffer count");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.kind == KindText || out_data_o.kind == KindErr ||
                     out_data_o.kind == KindDone))
    else $error("bad result kind");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !in_fire) |=> (rem_q == $past(rem_q) - 3'd1))
    else $error("buffer count did not step down");

endmodule
`default_nettype wire
